>>> hw/rtl/cpp_pkg.sv
package cpp_pkg;

   localparam int CORDIC_STAGES_DEF = 24;

   localparam int VEC_W  = 60;   // vectoring datapath: 33-bit delta << 24 plus CORDIC growth
   localparam int ROT_W  = 50;   // rotation datapath: x0 < 2^47 plus growth
   localparam int RZ_W   = 34;   // rotation residual angle
   localparam int NUM_W  = 61;   // arc_distance * TURN_PER_RAD
   localparam int DIV_BITS = NUM_W;
   localparam int X0_W   = 47;
   localparam int SQ_W   = 62;

   localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_RADIUS   = 2'd2;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [30:0]        arc_distance;
      logic               counterclockwise;
   } req_payload_type;

   typedef struct packed {
      logic               inside_res;
      logic               on_circle;
      logic signed [31:0] proj_x;
      logic signed [31:0] proj_y;
      logic signed [31:0] moved_x;
      logic signed [31:0] moved_y;
      logic               degenerate;
   } rsp_payload_type;

   typedef struct packed {
      logic valid;
      logic ccw;
      logic zero;
      logic in_circle;
      logic on;
   } meta_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [31:0]             z;
   } vec_state_type;

   typedef struct packed {
      logic [30:0]      rem;
      logic [NUM_W-1:0] num;
      logic [31:0]      quo;
   } div_state_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [RZ_W-1:0]  z;
   } rot_state_type;

   // arctan(2^-i) as a binary angle, full turn = 2^32
   function automatic logic [31:0] atan_bam(input int i);
      logic [31:0] r;
      case (i)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/cpp_front.sv
module cpp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  cpp_pkg::req_payload_type in_data,
   input  logic signed [31:0]       center_x,
   input  logic signed [31:0]       center_y,
   input  logic [cpp_pkg::SQ_W-1:0] r2,
   output cpp_pkg::meta_type        out_meta,
   output cpp_pkg::vec_state_type   out_vec,
   output logic [cpp_pkg::NUM_W-1:0] out_num
);
   import cpp_pkg::*;

   localparam logic signed [32:0] LIM = 33'sd2147483648;

   logic signed [32:0] dx_in, dy_in, ndx_in, ndy_in;
   logic [30:0]        ax_in, ay_in;
   logic               near_in;
   logic [NUM_W-1:0]   num_in;

   logic               s1_valid_ff, s1_ccw_ff, s1_near_ff;
   logic signed [32:0] s1_dx_ff, s1_dy_ff;
   logic [30:0]        s1_ax_ff, s1_ay_ff;
   logic [NUM_W-1:0]   s1_num_ff;

   logic                s2_valid_ff, s2_ccw_ff, s2_near_ff, s2_zero_ff;
   logic [SQ_W-1:0]     s2_sqx_ff, s2_sqy_ff;
   vec_state_type       s2_vec_ff, vec_in;
   logic [NUM_W-1:0]    s2_num_ff;

   logic [SQ_W:0]       d2;
   meta_type            s3_meta_ff, meta_in;
   vec_state_type       s3_vec_ff;
   logic [NUM_W-1:0]    s3_num_ff;

   logic signed [VEC_W-1:0] dxw, dyw;

   always_comb begin
      dx_in  = 33'(in_data.point_x) - 33'(center_x);
      dy_in  = 33'(in_data.point_y) - 33'(center_y);
      ndx_in = 33'(center_x) - 33'(in_data.point_x);
      ndy_in = 33'(center_y) - 33'(in_data.point_y);
      ax_in  = dx_in[32] ? ndx_in[30:0] : dx_in[30:0];
      ay_in  = dy_in[32] ? ndy_in[30:0] : dy_in[30:0];
      near_in = (dx_in > -LIM) && (dx_in < LIM) && (dy_in > -LIM) && (dy_in < LIM);
      num_in = NUM_W'(in_data.arc_distance) * NUM_W'(TURN_PER_RAD);
   end

   always_comb begin
      dxw = VEC_W'(s1_dx_ff);
      dyw = VEC_W'(s1_dy_ff);
      if (s1_dx_ff[32]) begin
         dxw = -dxw;
         dyw = -dyw;
      end
      vec_in.x = dxw <<< 24;
      vec_in.y = dyw <<< 24;
      vec_in.z = s1_dx_ff[32] ? 32'h8000_0000 : 32'h0;
   end

   always_comb begin
      d2 = (SQ_W+1)'(s2_sqx_ff) + (SQ_W+1)'(s2_sqy_ff);
      meta_in.valid     = s2_valid_ff;
      meta_in.ccw       = s2_ccw_ff;
      meta_in.zero      = s2_zero_ff;
      meta_in.in_circle = s2_near_ff && (d2 <= (SQ_W+1)'(r2));
      meta_in.on        = s2_near_ff && (d2 == (SQ_W+1)'(r2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_meta_ff  <= '0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_meta_ff  <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ccw_ff  <= in_data.counterclockwise;
         s1_near_ff <= near_in;
         s1_dx_ff   <= dx_in;
         s1_dy_ff   <= dy_in;
         s1_ax_ff   <= ax_in;
         s1_ay_ff   <= ay_in;
         s1_num_ff  <= num_in;

         s2_ccw_ff  <= s1_ccw_ff;
         s2_near_ff <= s1_near_ff;
         s2_zero_ff <= (s1_dx_ff == 33'sd0) && (s1_dy_ff == 33'sd0);
         s2_sqx_ff  <= SQ_W'(s1_ax_ff) * SQ_W'(s1_ax_ff);
         s2_sqy_ff  <= SQ_W'(s1_ay_ff) * SQ_W'(s1_ay_ff);
         s2_vec_ff  <= vec_in;
         s2_num_ff  <= s1_num_ff;

         s3_vec_ff  <= s2_vec_ff;
         s3_num_ff  <= s2_num_ff;
      end
   end

   assign out_meta = s3_meta_ff;
   assign out_vec  = s3_vec_ff;
   assign out_num  = s3_num_ff;

endmodule

>>> hw/rtl/cpp_vec_cell.sv
module cpp_vec_cell #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  cpp_pkg::vec_state_type d_in,
   output cpp_pkg::vec_state_type d_out
);
   import cpp_pkg::*;

   vec_state_type state_ff, state_in;
   logic signed [VEC_W-1:0] xs, ys;

   always_comb begin
      xs = d_in.x >>> STAGE;
      ys = d_in.y >>> STAGE;
      if (d_in.y[VEC_W-1]) begin
         state_in.x = d_in.x - ys;
         state_in.y = d_in.y + xs;
         state_in.z = d_in.z - atan_bam(STAGE);
      end else begin
         state_in.x = d_in.x + ys;
         state_in.y = d_in.y - xs;
         state_in.z = d_in.z + atan_bam(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign d_out = state_ff;

endmodule

>>> hw/rtl/cpp_div_cell.sv
module cpp_div_cell (
   input  logic                   clock,
   input  logic                   en,
   input  logic [30:0]            divisor,
   input  cpp_pkg::div_state_type d_in,
   output cpp_pkg::div_state_type d_out
);
   import cpp_pkg::*;

   div_state_type state_ff, state_in;
   logic [31:0]   trial, diff;
   logic          ge;

   // one restoring step: bring down the next numerator bit
   always_comb begin
      trial = {d_in.rem, d_in.num[NUM_W-1]};
      diff  = trial - {1'b0, divisor};
      ge    = trial >= {1'b0, divisor};
      state_in.rem = ge ? diff[30:0] : trial[30:0];
      state_in.num = {d_in.num[NUM_W-2:0], 1'b0};
      state_in.quo = {d_in.quo[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign d_out = state_ff;

endmodule

>>> hw/rtl/cpp_rot_cell.sv
module cpp_rot_cell #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  cpp_pkg::rot_state_type d_in,
   output cpp_pkg::rot_state_type d_out
);
   import cpp_pkg::*;

   rot_state_type state_ff, state_in;
   logic signed [ROT_W-1:0] xs, ys;
   logic signed [RZ_W-1:0]  at;

   always_comb begin
      xs = d_in.x >>> STAGE;
      ys = d_in.y >>> STAGE;
      at = $signed({{(RZ_W-32){1'b0}}, atan_bam(STAGE)});
      if (!d_in.z[RZ_W-1]) begin
         state_in.x = d_in.x - ys;
         state_in.y = d_in.y + xs;
         state_in.z = d_in.z - at;
      end else begin
         state_in.x = d_in.x + ys;
         state_in.y = d_in.y - xs;
         state_in.z = d_in.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign d_out = state_ff;

endmodule

>>> hw/rtl/circle_point_project_and_arc_step_core.sv
// Channel   Ports                              Moves
// req       req_valid/req_ready/req_payload    point, arc distance, direction
// rsp       rsp_valid/rsp_ready/rsp_payload    flags, projection, moved point
// csr       csr_we/csr_index/csr_wdata         center_x, center_y, radius
//
// One transaction per cycle in and out. A transaction passes 3 front registers, the
// 61-cell restoring divider for the angle step, 2 angle setup registers,
// CORDIC_STAGES rotation cells and the output register.
// Synchronous reset clears the config registers and all stage valid bits.
// The whole pipeline advances when the output register is empty or taken.
module circle_point_project_and_arc_step_core #(
   parameter int CORDIC_STAGES = cpp_pkg::CORDIC_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cpp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cpp_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata
);
   import cpp_pkg::*;

   localparam int TH_DEPTH = DIV_BITS - CORDIC_STAGES;

   logic signed [31:0] center_x_ff, center_y_ff;
   logic [30:0]        radius_ff;
   logic [X0_W-1:0]    x0_ff;
   logic [SQ_W-1:0]    r2_ff;
   logic [NUM_W-1:0]   x0_full;

   logic adv;

   meta_type        front_meta;
   vec_state_type   vec_s [CORDIC_STAGES+1];
   div_state_type   div_s [DIV_BITS+1];
   rot_state_type   rotp_s [CORDIC_STAGES+1];
   rot_state_type   rotm_s [CORDIC_STAGES+1];
   logic [NUM_W-1:0] front_num;

   meta_type    dmeta_ff [DIV_BITS];
   logic [31:0] th_ff [TH_DEPTH];
   meta_type    rmeta_ff [CORDIC_STAGES];

   meta_type    sa_meta_ff, sb_meta_ff;
   logic [31:0] sa_ang_p_ff, sa_ang_m_ff;
   logic [31:0] theta, q, ang_p_in, ang_m_in;
   rot_state_type sb_rotp_ff, sb_rotm_ff;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;
   meta_type        last_meta;

   function automatic rot_state_type rot_init(input logic [31:0] a,
                                              input logic [X0_W-1:0] x0);
      rot_state_type r;
      logic signed [RZ_W-1:0]  za;
      logic signed [ROT_W-1:0] xw;
      za = RZ_W'($signed(a));
      xw = $signed({{(ROT_W-X0_W){1'b0}}, x0});
      r.y = '0;
      if (za > 34'sd1073741824) begin
         r.z = za - 34'sd2147483648;
         r.x = -xw;
      end else if (za < -34'sd1073741824) begin
         r.z = za + 34'sd2147483648;
         r.x = -xw;
      end else begin
         r.z = za;
         r.x = xw;
      end
      return r;
   endfunction

   // round Q34.16 to a signed integer, add the center, saturate
   function automatic logic signed [31:0] to_coord(input logic signed [ROT_W-1:0] v,
                                                   input logic signed [31:0] c);
      logic signed [ROT_W-1:0] vr;
      logic signed [35:0]      s;
      logic signed [31:0]      r;
      vr = v + ROT_W'(32768);
      s  = 36'($signed(vr[ROT_W-1:16])) + 36'(c);
      if (s > 36'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (s < -36'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // config registers
   assign x0_full = NUM_W'(radius_ff) * NUM_W'(INV_GAIN_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
         x0_ff       <= '0;
         r2_ff       <= '0;
      end else begin
         x0_ff <= x0_full[NUM_W-1:14];
         r2_ff <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
         if (csr_we) begin
            unique case (csr_index)
               CSR_CENTER_X: center_x_ff <= csr_wdata;
               CSR_CENTER_Y: center_y_ff <= csr_wdata;
               CSR_RADIUS:   radius_ff   <= csr_wdata[30:0];
               default: ;
            endcase
         end
      end
   end

   cpp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .in_data  (req_payload),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .r2       (r2_ff),
      .out_meta (front_meta),
      .out_vec  (vec_s[0]),
      .out_num  (front_num)
   );

   assign div_s[0].rem = '0;
   assign div_s[0].num = front_num;
   assign div_s[0].quo = '0;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
      cpp_vec_cell #(.STAGE(k)) u_cell (
         .clock (clock),
         .en    (adv),
         .d_in  (vec_s[k]),
         .d_out (vec_s[k+1])
      );
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      cpp_div_cell u_cell (
         .clock   (clock),
         .en      (adv),
         .divisor (radius_ff),
         .d_in    (div_s[k]),
         .d_out   (div_s[k+1])
      );
   end

   // side data travels alongside the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            dmeta_ff[k] <= '0;
         end
      end else if (adv) begin
         dmeta_ff[0] <= front_meta;
         for (int k = 1; k < DIV_BITS; k++) begin
            dmeta_ff[k] <= dmeta_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         th_ff[0] <= vec_s[CORDIC_STAGES].z;
         for (int k = 1; k < TH_DEPTH; k++) begin
            th_ff[k] <= th_ff[k-1];
         end
      end
   end

   always_comb begin
      theta    = dmeta_ff[DIV_BITS-1].zero ? 32'h0 : th_ff[TH_DEPTH-1];
      q        = (radius_ff == 31'd0) ? 32'h0 : div_s[DIV_BITS].quo;
      ang_p_in = theta;
      ang_m_in = dmeta_ff[DIV_BITS-1].ccw ? theta + q : theta - q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_meta_ff <= '0;
         sb_meta_ff <= '0;
      end else if (adv) begin
         sa_meta_ff <= dmeta_ff[DIV_BITS-1];
         sb_meta_ff <= sa_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ang_p_ff <= ang_p_in;
         sa_ang_m_ff <= ang_m_in;
         sb_rotp_ff  <= rot_init(sa_ang_p_ff, x0_ff);
         sb_rotm_ff  <= rot_init(sa_ang_m_ff, x0_ff);
      end
   end

   assign rotp_s[0] = sb_rotp_ff;
   assign rotm_s[0] = sb_rotm_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      cpp_rot_cell #(.STAGE(k)) u_proj (
         .clock (clock),
         .en    (adv),
         .d_in  (rotp_s[k]),
         .d_out (rotp_s[k+1])
      );
      cpp_rot_cell #(.STAGE(k)) u_move (
         .clock (clock),
         .en    (adv),
         .d_in  (rotm_s[k]),
         .d_out (rotm_s[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_STAGES; k++) begin
            rmeta_ff[k] <= '0;
         end
      end else if (adv) begin
         rmeta_ff[0] <= sb_meta_ff;
         for (int k = 1; k < CORDIC_STAGES; k++) begin
            rmeta_ff[k] <= rmeta_ff[k-1];
         end
      end
   end

   always_comb begin
      last_meta          = rmeta_ff[CORDIC_STAGES-1];
      rsp_in.inside_res  = last_meta.in_circle;
      rsp_in.on_circle   = last_meta.on;
      rsp_in.proj_x      = to_coord(rotp_s[CORDIC_STAGES].x, center_x_ff);
      rsp_in.proj_y      = to_coord(rotp_s[CORDIC_STAGES].y, center_y_ff);
      rsp_in.moved_x     = to_coord(rotm_s[CORDIC_STAGES].x, center_x_ff);
      rsp_in.moved_y     = to_coord(rotm_s[CORDIC_STAGES].y, center_y_ff);
      rsp_in.degenerate  = last_meta.zero || (radius_ff == 31'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last_meta.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
